// File: rtl/ldr_sample_to_lux_averager_assert.svh
// ----------------------------------------------------------------------------
// LDR lux averager assertion macros
// Short forms for the clocked checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef LDR_SAMPLE_TO_LUX_AVERAGER_ASSERT_SVH
`define LDR_SAMPLE_TO_LUX_AVERAGER_ASSERT_SVH

// condition c holds in the same cycle as a
`define LDR_ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("ldr lux averager check failed");

// condition c holds in the cycle after a
`define LDR_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("ldr lux averager check failed");

`endif

// File: rtl/ldr_lux_pkg.sv
// ----------------------------------------------------------------------------
// LDR lux averager package
// Shared types, state codes and fixed-point constants.
// ----------------------------------------------------------------------------
package ldr_lux_pkg;

    // shared divider sizes
    localparam int DIV_DW = 48;
    localparam int DIV_SW = 24;
    localparam int DIV_CW = 6;

    // shared multiplier operand width
    localparam int MUL_W = 32;

    // register map
    localparam int REG_ADDR_W = 4;
    localparam logic [1:0] REG_SAMPLE_COUNT = 2'd0;
    localparam logic [1:0] REG_SLOPE_M      = 2'd1;
    localparam logic [1:0] REG_INTERCEPT_B  = 2'd2;

    localparam logic [6:0]  SAMPLE_COUNT_RST = 7'd1;
    localparam logic [15:0] SLOPE_M_RST      = 16'hF400;   // -0.75 in Q4.12
    localparam logic [15:0] INTERCEPT_B_RST  = 16'h5000;   // 5.0 in Q4.12

    // conversion constants
    localparam logic [MUL_W-1:0] ADC_FULL    = 32'd4095;
    localparam logic [MUL_W-1:0] LOG10_2_Q32 = 32'd1292913986;
    localparam logic [MUL_W-1:0] LOG2_10_Q28 = 32'd891723283;
    localparam logic [23:0]      LUX_MAX     = 24'hFFFFFF;
    localparam logic [31:0]      R_MAX       = 32'hFFFFFFFF;
    localparam logic [47:0]      T_SAT_HI    = 48'd458752;  // 7.0 in Q16
    localparam logic [47:0]      T_ZERO_LO   = 48'd196608;  // 3.0 in Q16
    localparam logic [50:0]      W_BIAS      = 51'h4000_0000_0000;  // 4.0 in Q44
    localparam logic [6:0]       EI_LIMIT    = 7'd24;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_SW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_DW-1:0] quotient;
    } div_rsp_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_V_MUL,
        ST_V_DIV,
        ST_V_WAIT,
        ST_R_MUL,
        ST_R_DIV,
        ST_R_WAIT,
        ST_LUX_SEL,
        ST_NORM,
        ST_SQ_MUL,
        ST_SQ_UPD,
        ST_L10_MUL,
        ST_T_DIV,
        ST_T_WAIT,
        ST_W_MUL,
        ST_W_CHK,
        ST_SQRT_LOAD,
        ST_SQRT_STEP,
        ST_LUX_SHIFT,
        ST_ACC,
        ST_MV_DIV,
        ST_MV_WAIT,
        ST_MR_DIV,
        ST_MR_WAIT,
        ST_ML_DIV,
        ST_ML_WAIT,
        ST_OUT
    } state_t;

endpackage

// File: rtl/ldr_lux_div.sv
// ----------------------------------------------------------------------------
// LDR lux divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ldr_lux_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ldr_lux_pkg::div_req_t req,
    output ldr_lux_pkg::div_rsp_t rsp
);

    logic [ldr_lux_pkg::DIV_SW-1:0] rem_reg, rem_next;
    logic [ldr_lux_pkg::DIV_DW-1:0] quo_reg, quo_next;
    logic [ldr_lux_pkg::DIV_SW-1:0] dvs_reg, dvs_next;
    logic [ldr_lux_pkg::DIV_CW-1:0] cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [ldr_lux_pkg::DIV_SW:0]   trial;
    logic                           fits;

    // one shift-subtract step
    assign trial = {rem_reg, quo_reg[ldr_lux_pkg::DIV_DW-1]};
    assign fits  = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? ldr_lux_pkg::DIV_SW'(trial - {1'b0, dvs_reg})
                            : trial[ldr_lux_pkg::DIV_SW-1:0];
            quo_next = {quo_reg[ldr_lux_pkg::DIV_DW-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == ldr_lux_pkg::DIV_CW'(ldr_lux_pkg::DIV_DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// File: rtl/ldr_sample_to_lux_averager.sv
// ----------------------------------------------------------------------------
// LDR sample to lux averager
// Converts divider ADC samples to voltage, LDR resistance and lux, and
// emits the means over a configured number of samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one 12-bit ADC sample per request. m_* carries one result
//   per batch: mean voltage (uV), mean resistance (ohm), mean lux (Q20.4),
//   and a saturation flag in tuser. An APB port sets sample_count, slope_m
//   and intercept_b; change them only while the block is idle.
//   Each sample is worked through one shared 32x32 multiplier, one shared
//   48-bit restoring divider and a bit-serial square root (32 steps for
//   each of 16 fraction bits) under one sequencer. The voltage divide by
//   4095 is a constant fold after two multiplies. The square root loop
//   dominates the work for a sample on the lux path. The last sample of
//   a batch adds three mean divisions. s_tready is high only while the
//   sequencer is idle. The result waits in an output register; a stalled
//   receiver holds the block only when the next batch result is ready
//   and the register is still full. Reset clears the accumulators, the
//   counters and the output valid flag, and loads sample_count=1,
//   slope_m=-0.75, intercept_b=5.0.
// ----------------------------------------------------------------------------
`include "ldr_sample_to_lux_averager_assert.svh"

module ldr_sample_to_lux_averager #(
    parameter int VCC_UV      = 3300000,
    parameter int SERIES_OHMS = 10000,
    parameter int MAX_SAMPLES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [ldr_lux_pkg::REG_ADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // sample requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] adc_code
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // [21:0] mean_voltage_uv, [53:22] mean_resistance_ohm,
                                   // [77:54] mean_lux_q4
    output logic        m_tuser    // [0] saturated
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int NW    = (CNT_W > 7) ? CNT_W : 7;
    localparam int VS_W  = 22 + CNT_W;
    localparam int RS_W  = 32 + CNT_W;
    localparam int LS_W  = 24 + CNT_W;

    // voltage = code * V_Q + floor(code * V_R / 4095)
    localparam int V_Q   = VCC_UV / int'(ldr_lux_pkg::ADC_FULL);
    localparam int V_R   = VCC_UV % int'(ldr_lux_pkg::ADC_FULL);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [6:0]  sample_count_reg;
    logic [15:0] slope_m_reg;
    logic [15:0] intercept_b_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= ldr_lux_pkg::SAMPLE_COUNT_RST;
            slope_m_reg      <= ldr_lux_pkg::SLOPE_M_RST;
            intercept_b_reg  <= ldr_lux_pkg::INTERCEPT_B_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                ldr_lux_pkg::REG_SAMPLE_COUNT: sample_count_reg <= pwdata[6:0];
                ldr_lux_pkg::REG_SLOPE_M:      slope_m_reg      <= pwdata[15:0];
                ldr_lux_pkg::REG_INTERCEPT_B:  intercept_b_reg  <= pwdata[15:0];
                default:                       ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[3:2])
            ldr_lux_pkg::REG_SAMPLE_COUNT: prdata = {25'd0, sample_count_reg};
            ldr_lux_pkg::REG_SLOPE_M:      prdata = {16'd0, slope_m_reg};
            ldr_lux_pkg::REG_INTERCEPT_B:  prdata = {16'd0, intercept_b_reg};
            default:                       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer and datapath registers
    // ------------------------------------------------------------------
    ldr_lux_pkg::state_t state_reg, state_next;

    logic [11:0]      code_reg, code_next;
    logic [21:0]      v_reg, v_next;
    logic [31:0]      r_reg, r_next;
    logic [23:0]      lux_reg, lux_next;
    logic             sat_reg, sat_next;
    logic [31:0]      x_reg, x_next;
    logic [4:0]       e_reg, e_next;
    logic [15:0]      frac_reg, frac_next;
    logic [3:0]       k_reg, k_next;
    logic             tneg_reg, tneg_next;
    logic [19:0]      tmag_reg, tmag_next;
    logic [4:0]       ei_reg, ei_next;
    logic [15:0]      f_reg, f_next;
    logic [31:0]      y_reg, y_next;
    logic [63:0]      op_reg, op_next;
    logic [63:0]      res_reg, res_next;
    logic [4:0]       j_reg, j_next;
    logic [63:0]      prod_reg;
    logic [21:0]      mv_reg, mv_next;
    logic [31:0]      mr_reg, mr_next;
    logic [23:0]      ml_reg, ml_next;

    logic [VS_W-1:0]  vsum_reg, vsum_next;
    logic [RS_W-1:0]  rsum_reg, rsum_next;
    logic [LS_W-1:0]  lsum_reg, lsum_next;
    logic [CNT_W-1:0] st_reg, st_next;
    logic             any_sat_reg, any_sat_next;

    logic             out_valid_reg, out_valid_next;
    logic [21:0]      out_v_reg;
    logic [31:0]      out_r_reg;
    logic [23:0]      out_l_reg;
    logic             out_sat_reg;
    logic             out_load;

    // shared units
    ldr_lux_pkg::div_req_t div_req;
    ldr_lux_pkg::div_rsp_t div_rsp;
    logic [ldr_lux_pkg::MUL_W-1:0] mul_a, mul_b;

    ldr_lux_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // derived values
    // ------------------------------------------------------------------
    logic              m_zero, m_neg;
    logic [15:0]       m_mag;
    logic [24:0]       v_fold_sum;
    logic [21:0]       v_lo;
    logic [21:0]       v_calc;
    logic [20:0]       l10;
    logic signed [22:0] diff;
    logic [22:0]       diff_mag;
    logic [32:0]       sq;
    logic [49:0]       wp;
    logic [50:0]       wv;
    logic              w_neg;
    logic [32:0]       yy;
    logic [63:0]       one;
    logic [63:0]       trial_sum;
    logic              root_fits;
    logic [55:0]       lux_sh;
    logic [NW-1:0]     n_eff;
    logic [NW-1:0]     sc_ext;
    logic [CNT_W-1:0]  st_inc;
    logic              batch_done;

    assign m_zero   = (slope_m_reg == 16'd0);
    assign m_neg    = slope_m_reg[15];
    assign m_mag    = m_neg ? 16'(-slope_m_reg) : slope_m_reg;

    // floor(x / 4095) for x < 4095*4096: (x + (x >> 12) + 1) >> 12
    assign v_fold_sum = {1'b0, prod_reg[23:0]} + {13'd0, prod_reg[23:12]} + 25'd1;
    assign v_lo       = 22'(v_fold_sum[24:12]);
    assign v_calc     = v_reg + prod_reg[21:0];

    // log10 R in Q16 and numerator of t
    assign l10      = prod_reg[52:32];
    assign diff     = $signed({2'b00, l10})
                    - $signed({{3{intercept_b_reg[15]}}, intercept_b_reg, 4'b0000});
    assign diff_mag = diff[22] ? 23'(-diff) : 23'(diff);

    // squaring step of the log loop
    assign sq       = prod_reg[63:31];

    // exponent in Q44 around the bias
    assign wp       = prod_reg[49:0];
    assign w_neg    = tneg_reg && ({1'b0, wp} > ldr_lux_pkg::W_BIAS);
    assign wv       = tneg_reg ? (ldr_lux_pkg::W_BIAS - {1'b0, wp})
                               : (ldr_lux_pkg::W_BIAS + {1'b0, wp});

    // square root step
    assign yy        = f_reg[k_reg] ? {y_reg, 1'b0} : {1'b0, y_reg};
    assign one       = 64'd1 << {j_reg, 1'b0};
    assign trial_sum = res_reg + one;
    assign root_fits = (op_reg >= trial_sum);

    // final scale by the integer exponent
    assign lux_sh    = {24'd0, y_reg} << ei_reg;

    // batch length
    assign sc_ext     = NW'(sample_count_reg);
    assign n_eff      = (sample_count_reg == 7'd0) ? NW'(1)
                      : ((sc_ext > NW'(MAX_SAMPLES)) ? NW'(MAX_SAMPLES) : sc_ext);
    assign st_inc     = st_reg + 1'b1;
    assign batch_done = (NW'(st_inc) >= n_eff);

    assign out_load   = (state_reg == ldr_lux_pkg::ST_OUT) && (!out_valid_reg || m_tready);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ldr_lux_pkg::ST_IDLE:
                if (s_tvalid) state_next = ldr_lux_pkg::ST_V_MUL;
            ldr_lux_pkg::ST_V_MUL:   state_next = ldr_lux_pkg::ST_V_DIV;
            ldr_lux_pkg::ST_V_DIV:   state_next = ldr_lux_pkg::ST_V_WAIT;
            ldr_lux_pkg::ST_V_WAIT:
                state_next = (v_calc == 22'd0) ? ldr_lux_pkg::ST_LUX_SEL
                                               : ldr_lux_pkg::ST_R_MUL;
            ldr_lux_pkg::ST_R_MUL:   state_next = ldr_lux_pkg::ST_R_DIV;
            ldr_lux_pkg::ST_R_DIV:   state_next = ldr_lux_pkg::ST_R_WAIT;
            ldr_lux_pkg::ST_R_WAIT:
                if (div_rsp.done) state_next = ldr_lux_pkg::ST_LUX_SEL;
            ldr_lux_pkg::ST_LUX_SEL:
                if (m_zero || v_reg == 22'd0 || r_reg == 32'd0)
                    state_next = ldr_lux_pkg::ST_ACC;
                else
                    state_next = ldr_lux_pkg::ST_NORM;
            ldr_lux_pkg::ST_NORM:
                if (x_reg[31]) state_next = ldr_lux_pkg::ST_SQ_MUL;
            ldr_lux_pkg::ST_SQ_MUL:  state_next = ldr_lux_pkg::ST_SQ_UPD;
            ldr_lux_pkg::ST_SQ_UPD:
                state_next = (k_reg == 4'd15) ? ldr_lux_pkg::ST_L10_MUL : ldr_lux_pkg::ST_SQ_MUL;
            ldr_lux_pkg::ST_L10_MUL: state_next = ldr_lux_pkg::ST_T_DIV;
            ldr_lux_pkg::ST_T_DIV:   state_next = ldr_lux_pkg::ST_T_WAIT;
            ldr_lux_pkg::ST_T_WAIT:
                if (div_rsp.done)
                begin
                    if (!tneg_reg && div_rsp.quotient > ldr_lux_pkg::T_SAT_HI)
                        state_next = ldr_lux_pkg::ST_ACC;
                    else if (tneg_reg && div_rsp.quotient > ldr_lux_pkg::T_ZERO_LO)
                        state_next = ldr_lux_pkg::ST_ACC;
                    else
                        state_next = ldr_lux_pkg::ST_W_MUL;
                end
            ldr_lux_pkg::ST_W_MUL:   state_next = ldr_lux_pkg::ST_W_CHK;
            ldr_lux_pkg::ST_W_CHK:
                if (w_neg || wv[50:44] >= ldr_lux_pkg::EI_LIMIT)
                    state_next = ldr_lux_pkg::ST_ACC;
                else
                    state_next = ldr_lux_pkg::ST_SQRT_LOAD;
            ldr_lux_pkg::ST_SQRT_LOAD: state_next = ldr_lux_pkg::ST_SQRT_STEP;
            ldr_lux_pkg::ST_SQRT_STEP:
                if (j_reg == 5'd0)
                    state_next = (k_reg == 4'd15) ? ldr_lux_pkg::ST_LUX_SHIFT
                                                  : ldr_lux_pkg::ST_SQRT_LOAD;
            ldr_lux_pkg::ST_LUX_SHIFT: state_next = ldr_lux_pkg::ST_ACC;
            ldr_lux_pkg::ST_ACC:
                state_next = batch_done ? ldr_lux_pkg::ST_MV_DIV : ldr_lux_pkg::ST_IDLE;
            ldr_lux_pkg::ST_MV_DIV:  state_next = ldr_lux_pkg::ST_MV_WAIT;
            ldr_lux_pkg::ST_MV_WAIT:
                if (div_rsp.done) state_next = ldr_lux_pkg::ST_MR_DIV;
            ldr_lux_pkg::ST_MR_DIV:  state_next = ldr_lux_pkg::ST_MR_WAIT;
            ldr_lux_pkg::ST_MR_WAIT:
                if (div_rsp.done) state_next = ldr_lux_pkg::ST_ML_DIV;
            ldr_lux_pkg::ST_ML_DIV:  state_next = ldr_lux_pkg::ST_ML_WAIT;
            ldr_lux_pkg::ST_ML_WAIT:
                if (div_rsp.done) state_next = ldr_lux_pkg::ST_OUT;
            ldr_lux_pkg::ST_OUT:
                if (out_load) state_next = ldr_lux_pkg::ST_IDLE;
            default:                 state_next = ldr_lux_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer outputs: handshake, divider request, multiplier operands
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg[ldr_lux_pkg::DIV_DW-1:0];
        div_req.divisor  = '0;
        mul_a            = '0;
        mul_b            = '0;
        case (state_reg)
            ldr_lux_pkg::ST_IDLE:
                s_tready = 1'b1;
            ldr_lux_pkg::ST_V_MUL:
            begin
                mul_a = 32'(code_reg);
                mul_b = 32'(V_R);
            end
            ldr_lux_pkg::ST_V_DIV:
            begin
                mul_a = 32'(code_reg);
                mul_b = 32'(V_Q);
            end
            ldr_lux_pkg::ST_R_MUL:
            begin
                mul_a = 32'(SERIES_OHMS);
                mul_b = 32'(VCC_UV) - 32'(v_reg);
            end
            ldr_lux_pkg::ST_R_DIV:
            begin
                div_req.start   = 1'b1;
                div_req.divisor = ldr_lux_pkg::DIV_SW'(v_reg);
            end
            ldr_lux_pkg::ST_SQ_MUL:
            begin
                mul_a = x_reg;
                mul_b = x_reg;
            end
            ldr_lux_pkg::ST_L10_MUL:
            begin
                mul_a = {11'd0, e_reg, frac_reg};
                mul_b = ldr_lux_pkg::LOG10_2_Q32;
            end
            ldr_lux_pkg::ST_T_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = {13'd0, diff_mag, 12'd0};
                div_req.divisor  = {8'd0, m_mag};
            end
            ldr_lux_pkg::ST_W_MUL:
            begin
                mul_a = {12'd0, tmag_reg};
                mul_b = ldr_lux_pkg::LOG2_10_Q28;
            end
            ldr_lux_pkg::ST_MV_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = ldr_lux_pkg::DIV_DW'(vsum_reg);
                div_req.divisor  = ldr_lux_pkg::DIV_SW'(st_reg);
            end
            ldr_lux_pkg::ST_MR_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = ldr_lux_pkg::DIV_DW'(rsum_reg);
                div_req.divisor  = ldr_lux_pkg::DIV_SW'(st_reg);
            end
            ldr_lux_pkg::ST_ML_DIV:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = ldr_lux_pkg::DIV_DW'(lsum_reg);
                div_req.divisor  = ldr_lux_pkg::DIV_SW'(st_reg);
            end
            default:
                ;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        code_next      = code_reg;
        v_next         = v_reg;
        r_next         = r_reg;
        lux_next       = lux_reg;
        sat_next       = sat_reg;
        x_next         = x_reg;
        e_next         = e_reg;
        frac_next      = frac_reg;
        k_next         = k_reg;
        tneg_next      = tneg_reg;
        tmag_next      = tmag_reg;
        ei_next        = ei_reg;
        f_next         = f_reg;
        y_next         = y_reg;
        op_next        = op_reg;
        res_next       = res_reg;
        j_next         = j_reg;
        mv_next        = mv_reg;
        mr_next        = mr_reg;
        ml_next        = ml_reg;
        vsum_next      = vsum_reg;
        rsum_next      = rsum_reg;
        lsum_next      = lsum_reg;
        st_next        = st_reg;
        any_sat_next   = any_sat_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (out_load)
            out_valid_next = 1'b1;

        case (state_reg)
            ldr_lux_pkg::ST_IDLE:
            begin
                code_next = s_tdata[11:0];
                sat_next  = 1'b0;
            end
            // remainder part of the voltage
            ldr_lux_pkg::ST_V_DIV:
                v_next = v_lo;
            ldr_lux_pkg::ST_V_WAIT:
            begin
                v_next = v_calc;
                if (v_calc == 22'd0)
                begin
                    // zero sample: open-circuit resistance
                    r_next   = ldr_lux_pkg::R_MAX;
                    sat_next = 1'b1;
                end
            end
            ldr_lux_pkg::ST_R_WAIT:
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient > 48'(ldr_lux_pkg::R_MAX))
                    begin
                        r_next   = ldr_lux_pkg::R_MAX;
                        sat_next = 1'b1;
                    end
                    else
                        r_next = div_rsp.quotient[31:0];
                end
            ldr_lux_pkg::ST_LUX_SEL:
            begin
                x_next = r_reg;
                e_next = 5'd31;
                if (m_zero)
                begin
                    lux_next = ldr_lux_pkg::LUX_MAX;
                    sat_next = 1'b1;
                end
                else if (v_reg == 22'd0)
                    lux_next = m_neg ? 24'd0 : ldr_lux_pkg::LUX_MAX;
                else if (r_reg == 32'd0)
                begin
                    // full-scale sample: shorted LDR
                    lux_next = m_neg ? ldr_lux_pkg::LUX_MAX : 24'd0;
                    sat_next = 1'b1;
                end
            end
            ldr_lux_pkg::ST_NORM:
            begin
                k_next    = 4'd0;
                frac_next = 16'd0;
                if (!x_reg[31])
                begin
                    x_next = {x_reg[30:0], 1'b0};
                    e_next = e_reg - 1'b1;
                end
            end
            ldr_lux_pkg::ST_SQ_UPD:
            begin
                frac_next = {frac_reg[14:0], sq[32]};
                x_next    = sq[32] ? sq[32:1] : sq[31:0];
                k_next    = k_reg + 1'b1;
            end
            ldr_lux_pkg::ST_T_DIV:
                tneg_next = diff[22] ^ m_neg;
            ldr_lux_pkg::ST_T_WAIT:
                if (div_rsp.done)
                begin
                    tmag_next = div_rsp.quotient[19:0];
                    if (!tneg_reg && div_rsp.quotient > ldr_lux_pkg::T_SAT_HI)
                    begin
                        lux_next = ldr_lux_pkg::LUX_MAX;
                        sat_next = 1'b1;
                    end
                    else if (tneg_reg && div_rsp.quotient > ldr_lux_pkg::T_ZERO_LO)
                        lux_next = 24'd0;
                end
            ldr_lux_pkg::ST_W_CHK:
            begin
                ei_next = wv[48:44];
                f_next  = wv[43:28];
                y_next  = 32'h4000_0000;
                k_next  = 4'd0;
                if (w_neg)
                    lux_next = 24'd0;
                else if (wv[50:44] >= ldr_lux_pkg::EI_LIMIT)
                begin
                    lux_next = ldr_lux_pkg::LUX_MAX;
                    sat_next = 1'b1;
                end
            end
            ldr_lux_pkg::ST_SQRT_LOAD:
            begin
                op_next  = {1'b0, yy, 30'd0};
                res_next = 64'd0;
                j_next   = 5'd31;
            end
            ldr_lux_pkg::ST_SQRT_STEP:
            begin
                if (root_fits)
                begin
                    op_next  = op_reg - trial_sum;
                    res_next = (res_reg >> 1) + one;
                end
                else
                    res_next = res_reg >> 1;
                j_next = j_reg - 1'b1;
                if (j_reg == 5'd0)
                begin
                    y_next = root_fits ? 32'((res_reg >> 1) + one) : 32'(res_reg >> 1);
                    k_next = k_reg + 1'b1;
                end
            end
            ldr_lux_pkg::ST_LUX_SHIFT:
                if (lux_sh[55:54] != 2'b00)
                begin
                    lux_next = ldr_lux_pkg::LUX_MAX;
                    sat_next = 1'b1;
                end
                else
                    lux_next = lux_sh[53:30];
            ldr_lux_pkg::ST_ACC:
            begin
                vsum_next    = vsum_reg + VS_W'(v_reg);
                rsum_next    = rsum_reg + RS_W'(r_reg);
                lsum_next    = lsum_reg + LS_W'(lux_reg);
                any_sat_next = any_sat_reg | sat_reg;
                st_next      = st_inc;
            end
            ldr_lux_pkg::ST_MV_WAIT:
                if (div_rsp.done) mv_next = div_rsp.quotient[21:0];
            ldr_lux_pkg::ST_MR_WAIT:
                if (div_rsp.done) mr_next = div_rsp.quotient[31:0];
            ldr_lux_pkg::ST_ML_WAIT:
                if (div_rsp.done) ml_next = div_rsp.quotient[23:0];
            ldr_lux_pkg::ST_OUT:
                if (out_load)
                begin
                    vsum_next    = '0;
                    rsum_next    = '0;
                    lsum_next    = '0;
                    st_next      = '0;
                    any_sat_next = 1'b0;
                end
            default:
                ;
        endcase
    end

    // control and accumulator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ldr_lux_pkg::ST_IDLE;
            vsum_reg      <= '0;
            rsum_reg      <= '0;
            lsum_reg      <= '0;
            st_reg        <= '0;
            any_sat_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            k_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            vsum_reg      <= vsum_next;
            rsum_reg      <= rsum_next;
            lsum_reg      <= lsum_next;
            st_reg        <= st_next;
            any_sat_reg   <= any_sat_next;
            out_valid_reg <= out_valid_next;
            k_reg         <= k_next;
            j_reg         <= j_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        v_reg    <= v_next;
        r_reg    <= r_next;
        lux_reg  <= lux_next;
        sat_reg  <= sat_next;
        x_reg    <= x_next;
        e_reg    <= e_next;
        frac_reg <= frac_next;
        tneg_reg <= tneg_next;
        tmag_reg <= tmag_next;
        ei_reg   <= ei_next;
        f_reg    <= f_next;
        y_reg    <= y_next;
        op_reg   <= op_next;
        res_reg  <= res_next;
        mv_reg   <= mv_next;
        mr_reg   <= mr_next;
        ml_reg   <= ml_next;
        prod_reg <= mul_a * mul_b;
        if (out_load)
        begin
            out_v_reg   <= mv_reg;
            out_r_reg   <= mr_reg;
            out_l_reg   <= ml_reg;
            out_sat_reg <= any_sat_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_l_reg, out_r_reg, out_v_reg};
    assign m_tuser  = out_sat_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `LDR_ASSERT_SAME(a_div_start_idle, clk, rst_n, div_req.start, !div_rsp.busy)
    `LDR_ASSERT_NEXT(a_accept_starts, clk, rst_n, s_tvalid && s_tready,
                     state_reg == ldr_lux_pkg::ST_V_MUL)
    `LDR_ASSERT_NEXT(a_batch_cleared, clk, rst_n, out_load,
                     st_reg == '0 && vsum_reg == '0 && !any_sat_reg && m_tvalid)
    `LDR_ASSERT_SAME(a_count_bound, clk, rst_n, state_reg == ldr_lux_pkg::ST_IDLE,
                     NW'(st_reg) < NW'(MAX_SAMPLES))

endmodule

// File: dv/ldr_sample_to_lux_averager_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LDR lux averager testbench
// Sends ADC samples through the stream input and programs the averaging
// count, slope and intercept over APB. A fixed-point predictor works out the
// batch means and the saturation flag, and each result is compared with it.
// ----------------------------------------------------------------------------

// Predicts batch means and checks results in order
class lux_batch_scoreboard;
    typedef struct {
        bit [21:0] volt_uv;
        bit [31:0] res_ohm;
        bit [23:0] lux_q4;
        bit        sat;
    } batch_mean_t;

    localparam longint unsigned VCC   = 3300000;
    localparam longint unsigned RSER  = 10000;
    localparam longint unsigned NMAX  = 64;
    localparam longint unsigned LUXMX = 64'hFFFFFF;
    localparam longint unsigned RMX   = 64'hFFFFFFFF;

    bit [6:0]  count_cfg;
    bit [15:0] slope_cfg;
    bit [15:0] icpt_cfg;

    longint unsigned n_taken, v_acc, r_acc, l_acc;
    bit              sat_acc;

    batch_mean_t pending_means[$];
    int          n_errors;
    int          n_checked;

    function new();
        count_cfg = ldr_lux_pkg::SAMPLE_COUNT_RST;
        slope_cfg = ldr_lux_pkg::SLOPE_M_RST;
        icpt_cfg  = ldr_lux_pkg::INTERCEPT_B_RST;
        n_taken = 0; v_acc = 0; r_acc = 0; l_acc = 0; sat_acc = 0;
        n_errors = 0; n_checked = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
        longint unsigned op, res, one;
        op = n; res = 0; one = 64'd1 << 62;
        while (one > op)
            one >>= 2;
        while (one != 0)
        begin
            if (op >= res + one)
            begin
                op  -= res + one;
                res  = (res >> 1) + one;
            end
            else
                res >>= 1;
            one >>= 2;
        end
        return res;
    endfunction

    // log2 in Q16 by repeated squaring of the mantissa
    function longint unsigned log2_fx(longint unsigned r);
        int unsigned     e;
        longint unsigned x, frac;
        e = 31; frac = 0;
        while (e > 0 && r[e] == 1'b0)
            e--;
        x = (r << (31 - e)) & 64'hFFFFFFFF;
        for (int k = 0; k < 16; k++)
        begin
            x = (x * x) >> 31;
            frac <<= 1;
            if (x >= (64'd1 << 32))
            begin
                frac |= 1;
                x >>= 1;
            end
        end
        return (longint'(e) << 16) | frac;
    endfunction

    // lux = 10^((log10 R - b)/m), Q20.4
    function longint unsigned lux_fx(longint unsigned r, longint m, longint b, inout bit sat);
        longint          l10, t, w;
        longint unsigned wq, f, y, lx;
        int unsigned     ei;
        l10 = longint'((log2_fx(r) * 64'd1292913986) >> 32);
        t = ((l10 - b * 16) * 4096) / m;
        if (t > 7 * 65536)
        begin
            sat = 1;
            return LUXMX;
        end
        if (t < -3 * 65536)
            return 0;
        w = t * 64'sd891723283 + (64'sd4 <<< 44);
        if (w < 0)
            return 0;
        wq = longint'(w) >> 28;
        if ((wq >> 16) >= 24)
        begin
            sat = 1;
            return LUXMX;
        end
        ei = 32'(wq >> 16);
        f  = wq & 16'hFFFF;
        y  = 64'd1 << 30;
        for (int k = 0; k < 16; k++)
        begin
            if (f[k])
                y <<= 1;
            y = int_sqrt(y << 30);
        end
        lx = (y << ei) >> 30;
        if (lx > LUXMX)
        begin
            sat = 1;
            lx  = LUXMX;
        end
        return lx;
    endfunction

    function void note_sample(bit [11:0] code);
        longint unsigned v, r, lx, n;
        longint          m, b;
        bit              sat;
        batch_mean_t     e;
        m = longint'($signed(slope_cfg));
        b = longint'($signed(icpt_cfg));
        sat = 0;
        v = (longint'(code) * VCC) / 4095;
        if (v == 0)
        begin
            r = RMX;
            sat = 1;
        end
        else
        begin
            r = RSER * (VCC - v) / v;
            if (r > RMX)
            begin
                r = RMX;
                sat = 1;
            end
        end
        // zero slope wins over the other lux rules
        if (m == 0)
        begin
            lx = LUXMX;
            sat = 1;
        end
        else if (v == 0)
            lx = (m < 0) ? 0 : LUXMX;
        else if (r == 0)
        begin
            sat = 1;
            lx = (m < 0) ? LUXMX : 0;
        end
        else
            lx = lux_fx(r, m, b, sat);

        v_acc += v; r_acc += r; l_acc += lx;
        sat_acc |= sat;
        n_taken++;

        n = count_cfg;
        if (n < 1)
            n = 1;
        if (n > NMAX)
            n = NMAX;
        if (n_taken < n)
            return;
        e.volt_uv = 22'(v_acc / n_taken);
        e.res_ohm = 32'(r_acc / n_taken);
        e.lux_q4  = 24'(l_acc / n_taken);
        e.sat     = sat_acc;
        pending_means.push_back(e);
        n_taken = 0; v_acc = 0; r_acc = 0; l_acc = 0; sat_acc = 0;
    endfunction

    function void check_result(bit [79:0] data, bit user);
        batch_mean_t e;
        bit          bad;
        n_checked++;
        if (pending_means.size() == 0)
        begin
            n_errors++;
            if (n_errors <= 10)
                $display("%0t: unexpected result data=%h sat=%b", $realtime, data, user);
            return;
        end
        e = pending_means.pop_front();
        bad = (data[21:0] != e.volt_uv) || (data[53:22] != e.res_ohm) ||
              (data[77:54] != e.lux_q4) || (user != e.sat);
        if (bad)
        begin
            n_errors++;
            if (n_errors <= 10)
                $display({"%0t: mismatch exp v=%0d r=%0d lux=%0d sat=%b",
                          " got v=%0d r=%0d lux=%0d sat=%b"},
                         $realtime, e.volt_uv, e.res_ohm, e.lux_q4, e.sat,
                         data[21:0], data[53:22], data[77:54], user);
        end
    endfunction
endclass

module ldr_sample_to_lux_averager_test;

    logic        clk;
    logic        rst_n;
    logic        psel, penable, pwrite;
    logic [ldr_lux_pkg::REG_ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid, s_tready;
    logic [15:0] s_tdata;    // [11:0] adc_code
    logic        m_tvalid, m_tready;
    logic [79:0] m_tdata;    // [21:0] volt, [53:22] resistance, [77:54] lux
    logic        m_tuser;    // [0] saturated

    lux_batch_scoreboard sb;
    bit calm;            // no random idling on either side
    bit hold_request;    // receiver holds off for a long stretch
    int n_sent;

    ldr_sample_to_lux_averager u_dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    initial
    begin
        #50ms;
        $display("ldr_sample_to_lux_averager_test: errors");
        $finish;
    end

    // receiver readiness
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (4000) @(posedge clk);
                hold_request = 0;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 36);
        end
    end

    // result monitor
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser);

    task automatic apb_write(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ldr_lux_pkg::REG_ADDR_W'(idx) << 2; pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            ldr_lux_pkg::REG_SAMPLE_COUNT: sb.count_cfg = val[6:0];
            ldr_lux_pkg::REG_SLOPE_M:      sb.slope_cfg = val[15:0];
            ldr_lux_pkg::REG_INTERCEPT_B:  sb.icpt_cfg  = val[15:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int cnt, int m, int b);
        apb_write(ldr_lux_pkg::REG_SAMPLE_COUNT, 32'(cnt));
        apb_write(ldr_lux_pkg::REG_SLOPE_M, 32'(m));
        apb_write(ldr_lux_pkg::REG_INTERCEPT_B, 32'(b));
    endtask

    // send one request, keeping tvalid high across back-to-back requests
    task automatic send_code(bit [11:0] code);
        if (!calm && $urandom_range(99) < 36)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, code};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_sample(code);
        n_sent++;
    endtask

    // wait for all results plus the time a partial batch sample may still take
    task automatic drain();
        @(posedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_means.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
    endtask

    function automatic bit [11:0] rand_code();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return 12'd0;
        if (pick < 10)
            return 12'hFFF;
        if (pick < 15)
            return 12'($urandom_range(1, 8));
        return 12'($urandom);
    endfunction

    initial
    begin
        bit [11:0] codes[];
        int cnt;
        codes = '{12'd0, 12'hFFF, 12'd1, 12'd2, 12'hFFE, 12'd2048,
                  12'd1000, 12'hAAA, 12'h555, 12'd3000, 12'd100};
        sb = new();
        calm = 0; hold_request = 0; n_sent = 0;
        rst_n <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        s_tvalid <= 1'b0; s_tdata <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // field extremes under reset settings
        foreach (codes[i])
            send_code(codes[i]);
        drain();

        // zero slope, then positive slope
        set_config(1, 0, 20480);
        send_code(0); send_code(12'hFFF); send_code(2048);
        drain();
        set_config(1, 3072, 20480);
        send_code(0); send_code(12'hFFF); send_code(2048); send_code(1);
        drain();
        // slope and intercept extremes
        set_config(1, 32767, -32768);
        send_code(1); send_code(2048);
        drain();
        set_config(1, -32768, 32767);
        send_code(1); send_code(4000);
        drain();
        // count of zero and above the limit
        set_config(0, -3072, 20480);
        send_code(500); send_code(3500);
        drain();
        apb_write(ldr_lux_pkg::REG_SAMPLE_COUNT, 32'd127);
        repeat (64) send_code(rand_code());
        drain();
        // count lowered mid batch
        apb_write(ldr_lux_pkg::REG_SAMPLE_COUNT, 32'd8);
        send_code(700); send_code(1500); send_code(2500);
        drain();
        apb_write(ldr_lux_pkg::REG_SAMPLE_COUNT, 32'd2);
        send_code(3300);
        drain();

        // back-pressure: receiver stalls while the sender keeps offering
        apb_write(ldr_lux_pkg::REG_SAMPLE_COUNT, 32'd1);
        hold_request = 1;
        repeat (12) send_code(rand_code());
        drain();

        // random phases with random settings
        for (int ph = 0; n_sent < 520; ph++)
        begin
            calm = (ph == 3);
            case ($urandom_range(9))
                0:       cnt = 64;
                1:       cnt = $urandom_range(0, 1) ? 0 : 127;
                2, 3, 4: cnt = 1;
                default: cnt = $urandom_range(2, 6);
            endcase
            if ($urandom_range(3) == 0)
                set_config(cnt, int'($signed(16'($urandom))), int'($signed(16'($urandom))));
            else
                set_config(cnt, -$urandom_range(1024, 8192), $urandom_range(8192, 28672));
            repeat (cnt == 64 ? 64 : 30) send_code(rand_code());
            drain();
        end
        calm = 0;
        drain();

        $display("covered %0d samples, %0d results checked over several register settings",
                 n_sent, sb.n_checked);
        $display("with zero, full-scale, zero-slope and back-pressure cases; %0d mismatches",
                 sb.n_errors);
        if (sb.n_errors == 0 && sb.pending_means.size() == 0)
            $display("ldr_sample_to_lux_averager_test: clean");
        else
            $display("ldr_sample_to_lux_averager_test: errors");
        $finish;
    end
endmodule

// File: ldr_sample_to_lux_averager.f
+incdir+rtl
rtl/ldr_lux_pkg.sv
rtl/ldr_lux_div.sv
rtl/ldr_sample_to_lux_averager.sv
dv/ldr_sample_to_lux_averager_test.sv
